// ===== hw/rtl/sbt_pkg.sv =====
`default_nettype none
package sbt_pkg;

  localparam int CAPACITY = 64;
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  localparam int IN_TDATA_W  = 56;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 56;
  localparam int OUT_TUSER_W = 3;
  localparam int YEAR_W      = 12;

  localparam logic [YEAR_W-1:0] MIN_YEAR_RST = 12'd2022;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_INVALID   = 3'd1;
  localparam logic [2:0] ST_OVERLAP   = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_BAD_INDEX = 3'd5;

  // request as it arrives, full input widths
  typedef struct packed {
    logic [5:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
    logic [4:0]  start_hour;
    logic [5:0]  start_minute;
    logic [4:0]  end_hour;
    logic [5:0]  end_minute;
  } req_t;

  // stored entry; upper 32 bits form the sort key
  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  start_hour;
    logic [5:0]  start_minute;
    logic [4:0]  end_hour;
    logic [5:0]  end_minute;
  } bkg_t;

  typedef struct packed {
    logic date_eq;
    logic start_eq;
    logic key_gt;
    logic ovl;
  } cmp_t;

  function automatic bkg_t mk_bkg(input req_t r);
    bkg_t b;
    b.year         = r.year;
    b.month        = r.month;
    b.day          = r.day[4:0];
    b.start_hour   = r.start_hour;
    b.start_minute = r.start_minute;
    b.end_hour     = r.end_hour;
    b.end_minute   = r.end_minute;
    return b;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/sbt_check.sv =====
`default_nettype none
module sbt_check (
  input  sbt_pkg::req_t        req,
  input  logic [11:0]          min_year,
  output logic                 ok
);
  import sbt_pkg::*;

  logic day_ok, feb_ok, month_ok, year_ok, time_ok;

  always_comb begin
    day_ok   = (req.day >= 6'd1) && (req.day <= 6'd31);
    // february: at most 29, and 29 only in years divisible by four
    feb_ok   = !((req.month == 4'd2) && (req.day > 6'd29)) &&
               !((req.month == 4'd2) && (req.day == 6'd29) && (req.year[1:0] != 2'd0));
    month_ok = (req.month >= 4'd1) && (req.month <= 4'd12);
    year_ok  = (req.year >= min_year);
    time_ok  = (req.start_hour <= 5'd23) && (req.start_minute <= 6'd59) &&
               (req.end_hour <= 5'd23) && (req.end_minute <= 6'd59);
    ok       = day_ok && feb_ok && month_ok && year_ok && time_ok;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sbt_cmp.sv =====
`default_nettype none
module sbt_cmp (
  input  sbt_pkg::bkg_t ent,
  input  sbt_pkg::req_t req,
  output sbt_pkg::cmp_t res
);
  import sbt_pkg::*;

  logic [11:0] s_new, e_new, s_ent, e_ent;
  logic [32:0] key_new, key_ent;

  always_comb begin
    // times as 100*hour+minute
    s_new = 12'(req.start_hour) * 12'd100 + 12'(req.start_minute);
    e_new = 12'(req.end_hour) * 12'd100 + 12'(req.end_minute);
    s_ent = 12'(ent.start_hour) * 12'd100 + 12'(ent.start_minute);
    e_ent = 12'(ent.end_hour) * 12'd100 + 12'(ent.end_minute);

    key_new = {req.year, req.month, req.day, req.start_hour, req.start_minute};
    key_ent = {ent.year, ent.month, {1'b0, ent.day}, ent.start_hour, ent.start_minute};

    res.date_eq  = (ent.year == req.year) && (ent.month == req.month) &&
                   ({1'b0, ent.day} == req.day);
    res.start_eq = (ent.start_hour == req.start_hour) &&
                   (ent.start_minute == req.start_minute);
    res.key_gt   = key_ent > key_new;
    res.ovl      = res.date_eq &&
                   (((s_new > s_ent) && (s_new < e_ent)) ||
                    ((e_new > s_ent) && (e_new < e_ent)) ||
                    ((s_new < s_ent) && (e_new > e_ent)));
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sorted_booking_table_core.sv =====
// sorted booking table, kept in ascending date and start time order
//
// in_*: one beat per operation, in_tuser selects insert, remove or read.
// out_*: one result beat per operation, status in out_tuser, entry count
//   and the read entry in out_tdata (entry fields zero unless a read hits).
// cfg_*: min_year write, always ready; write only while the table is idle.
//
// one operation at a time; in_tready is high only while the sequencer idles.
// every table step goes through the single read port of the entry memory and
// one shared compare unit, one entry per cycle. the steps of each operation:
//   insert: overlap scan, then shift up to the slot
//   remove: match scan, then shift down
//   read:   one entry read; bad fields, bad index or a remove on an empty table go straight to the result
// the result is registered; the next beat is accepted while it waits, and
// the sequencer holds its final step until the output register frees up.
// reset empties the table by clearing the count; the memory is not swept,
// so the block is ready right after reset. min_year resets to 2022.
`default_nettype none
module sorted_booking_table_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // day, month, year, start_hour, start_minute, end_hour, end_minute, entry_index
  input  logic [sbt_pkg::IN_TDATA_W-1:0]       in_tdata,
  // operation
  input  logic [sbt_pkg::IN_TUSER_W-1:0]       in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // entry_count, out_day, out_month, out_year, out_start_hour, out_start_minute,
  // out_end_hour, out_end_minute
  output logic [sbt_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // status
  output logic [sbt_pkg::OUT_TUSER_W-1:0]      out_tuser,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [sbt_pkg::YEAR_W-1:0]           cfg_data
);
  import sbt_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_OVL     = 8'b0000_0010,
    S_SHIFT   = 8'b0000_0100,
    S_PLACE   = 8'b0000_1000,
    S_RMSCAN  = 8'b0001_0000,
    S_RMSHIFT = 8'b0010_0000,
    S_READ    = 8'b0100_0000,
    S_DONE    = 8'b1000_0000
  } state_t;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic [AW-1:0]     hit_r, hit_nxt;
  logic              found_r, found_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [YEAR_W-1:0] min_year_r;
  req_t              req_r;
  logic [5:0]        rd_idx_r;
  logic [2:0]        res_status_r, res_status_nxt;
  bkg_t              res_ent_r, res_ent_nxt;
  logic              out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [OUT_TUSER_W-1:0] out_user_r;

  bkg_t              mem [CAPACITY];
  bkg_t              rd_data_r;
  logic [AW-1:0]     rd_addr;
  logic              mem_we;
  logic [AW-1:0]     wr_addr;
  bkg_t              wr_data;

  req_t              in_req;
  logic [1:0]        in_op;
  logic              in_ok;
  logic              accept;
  cmp_t              cmp;
  logic              last_scan;
  logic              rm_match;
  logic              out_free;

  assign in_op = in_tuser[1:0];
  assign in_req = '{day:          in_tdata[5:0],
                    month:        in_tdata[9:6],
                    year:         in_tdata[21:10],
                    start_hour:   in_tdata[26:22],
                    start_minute: in_tdata[32:27],
                    end_hour:     in_tdata[37:33],
                    end_minute:   in_tdata[43:38]};

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;

  sbt_check u_check (
    .req      (in_req),
    .min_year (min_year_r),
    .ok       (in_ok)
  );

  sbt_cmp u_cmp (
    .ent (rd_data_r),
    .req (req_r),
    .res (cmp)
  );

  assign last_scan = (CW'(idx_r) + CW'(1)) == cnt_r;
  assign rm_match  = cmp.date_eq && cmp.start_eq;

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    hit_nxt        = hit_r;
    found_nxt      = found_r;
    cnt_nxt        = cnt_r;
    res_status_nxt = res_status_r;
    res_ent_nxt    = res_ent_r;
    rd_addr        = '0;
    mem_we         = 1'b0;
    wr_addr        = idx_r;
    wr_data        = rd_data_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_status_nxt = ST_OK;
          res_ent_nxt    = '0;
          idx_nxt        = '0;
          found_nxt      = 1'b0;
          case (in_op)
            OP_INSERT: begin
              if (!in_ok) begin
                res_status_nxt = ST_INVALID;
                state_nxt      = S_DONE;
              end else if (cnt_r == '0) begin
                state_nxt = S_PLACE;
              end else begin
                state_nxt = S_OVL;
              end
            end
            OP_REMOVE: begin
              if (cnt_r == '0) begin
                res_status_nxt = ST_NOT_FOUND;
                state_nxt      = S_DONE;
              end else begin
                state_nxt = S_RMSCAN;
              end
            end
            OP_READ: begin
              if (CW'(in_tdata[49:44]) >= cnt_r) begin
                res_status_nxt = ST_BAD_INDEX;
                state_nxt      = S_DONE;
              end else begin
                rd_addr   = AW'(in_tdata[49:44]);
                state_nxt = S_READ;
              end
            end
            default: begin
              res_status_nxt = ST_INVALID;
              state_nxt      = S_DONE;
            end
          endcase
        end
      end

      S_OVL: begin
        // rd_data_r holds entry idx_r
        if (cmp.ovl) begin
          res_status_nxt = ST_OVERLAP;
          state_nxt      = S_DONE;
        end else if (last_scan) begin
          if (cnt_r >= CW'(CAPACITY)) begin
            res_status_nxt = ST_FULL;
            state_nxt      = S_DONE;
          end else begin
            idx_nxt   = AW'(cnt_r);
            rd_addr   = AW'(cnt_r - CW'(1));
            state_nxt = S_SHIFT;
          end
        end else begin
          idx_nxt = idx_r + AW'(1);
          rd_addr = idx_r + AW'(1);
        end
      end

      S_SHIFT: begin
        // rd_data_r holds entry idx_r-1, idx_r is the free slot
        if (cmp.key_gt) begin
          mem_we  = 1'b1;
          wr_addr = idx_r;
          wr_data = rd_data_r;
          idx_nxt = idx_r - AW'(1);
          if (idx_r == AW'(1)) begin
            state_nxt = S_PLACE;
          end else begin
            rd_addr = idx_r - AW'(2);
          end
        end else begin
          mem_we    = 1'b1;
          wr_addr   = idx_r;
          wr_data   = mk_bkg(req_r);
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = S_DONE;
        end
      end

      S_PLACE: begin
        mem_we    = 1'b1;
        wr_addr   = idx_r;
        wr_data   = mk_bkg(req_r);
        cnt_nxt   = cnt_r + CW'(1);
        state_nxt = S_DONE;
      end

      S_RMSCAN: begin
        // keep the last match
        if (rm_match) begin
          hit_nxt   = idx_r;
          found_nxt = 1'b1;
        end
        if (last_scan) begin
          if (!found_nxt) begin
            res_status_nxt = ST_NOT_FOUND;
            state_nxt      = S_DONE;
          end else if ((CW'(hit_nxt) + CW'(1)) < cnt_r) begin
            idx_nxt   = hit_nxt;
            rd_addr   = hit_nxt + AW'(1);
            state_nxt = S_RMSHIFT;
          end else begin
            cnt_nxt   = cnt_r - CW'(1);
            state_nxt = S_DONE;
          end
        end else begin
          idx_nxt = idx_r + AW'(1);
          rd_addr = idx_r + AW'(1);
        end
      end

      S_RMSHIFT: begin
        // rd_data_r holds entry idx_r+1, moved down to idx_r
        mem_we  = 1'b1;
        wr_addr = idx_r;
        wr_data = rd_data_r;
        if ((CW'(idx_r) + CW'(2)) < cnt_r) begin
          idx_nxt = idx_r + AW'(1);
          rd_addr = idx_r + AW'(2);
        end else begin
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = S_DONE;
        end
      end

      S_READ: begin
        res_ent_nxt = rd_data_r;
        state_nxt   = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cnt_r      <= '0;
      min_year_r <= MIN_YEAR_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_valid && cfg_ready) begin
        min_year_r <= cfg_data;
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    hit_r        <= hit_nxt;
    found_r      <= found_nxt;
    res_status_r <= res_status_nxt;
    res_ent_r    <= res_ent_nxt;
    if (accept) begin
      req_r    <= in_req;
      rd_idx_r <= in_tdata[49:44];
    end
    if (state_r == S_DONE && out_free) begin
      out_user_r <= res_status_r;
      out_data_r <= {6'd0, res_ent_r.end_minute, res_ent_r.end_hour,
                     res_ent_r.start_minute, res_ent_r.start_hour, res_ent_r.year,
                     res_ent_r.month, res_ent_r.day, 7'(cnt_r)};
    end
  end

  // entry memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // a read that hits was checked against the count at accept
  ap_read_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> (CW'(rd_idx_r) < cnt_r))
    else $error("read index beyond entry count");

  ap_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  ap_write_addr: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (CW'(wr_addr) <= cnt_r))
    else $error("table write beyond the filled region");

  ap_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (cnt_r == $past(cnt_r) || cnt_r == $past(cnt_r) + CW'(1) ||
                      cnt_r == $past(cnt_r) - CW'(1)))
    else $error("entry count moved by more than one");

  ap_result_out: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(state_r == S_DONE) && state_r == S_IDLE) |-> out_tvalid)
    else $error("finished operation produced no result beat");

endmodule
`default_nettype wire
